### src/pfwc_pkg.sv
package pfwc_pkg;

    localparam int unsigned CRYSTAL_HZ_DEF = 26000000;
    localparam int unsigned RX_OFFSET_DIV  = 92;

    localparam int FREQ_W    = 32;
    localparam int DIVV_W    = 4;
    localparam int MUL_W     = FREQ_W + DIVV_W;
    localparam int FVCO_W    = 31;
    localparam int INT_W     = 8;
    localparam int FRAC_W    = 20;
    // fraction is worked out one 10-bit digit at a time
    localparam int DIG_W       = 10;
    localparam int FRAC_DIGITS = FRAC_W / DIG_W;
    localparam int CNT_W       = $clog2(FRAC_DIGITS + 1);

    localparam int NUM_DIVS = 5;
    localparam int IDX_W    = 3;

    localparam logic [MUL_W-1:0] HI_BAND_MIN = MUL_W'(64'd1680000000);
    localparam logic [MUL_W-1:0] HI_BAND_MAX = MUL_W'(64'd2040000000);
    localparam logic [MUL_W-1:0] LO_BAND_MIN = MUL_W'(64'd1516000000);
    localparam logic [MUL_W-1:0] LO_BAND_MAX = MUL_W'(64'd1680000000);

    localparam logic [2:0] VCO_BANK_HI = 3'd1;
    localparam logic [2:0] VCO_BANK_LO = 3'd6;

    localparam int BANK_BYTES = 8;
    localparam logic [7:0] BANK_RESET [BANK_BYTES] =
        '{8'h42, 8'h71, 8'hCE, 8'h1C, 8'h42, 8'h5B, 8'h1C, 8'h1C};

    // output divider, in search order
    function automatic logic [DIVV_W-1:0] div_value(input logic [IDX_W-1:0] idx);
        logic [DIVV_W-1:0] v;
        case (idx)
            3'd0:    v = 4'd4;
            3'd1:    v = 4'd6;
            3'd2:    v = 4'd8;
            3'd3:    v = 4'd12;
            3'd4:    v = 4'd2;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] div_code(input logic [IDX_W-1:0] idx);
        logic [2:0] c;
        case (idx)
            3'd0:    c = 3'd1;
            3'd1:    c = 3'd5;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd3;
            3'd4:    c = 3'd0;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_TX,
        OP_INC_DIV,
        OP_NEXT_BAND,
        OP_FAIL,
        OP_DIV_INIT,
        OP_Q_EST,
        OP_Q_MUL,
        OP_Q_SUB,
        OP_Q_FIX,
        OP_STORE_TX,
        OP_MUL_RX,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_IN_BAND,
        C_NOT_LAST_DIV,
        C_FIRST_BAND,
        C_CNT_NZ
    } t_cond;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc UPC_IDLE      = 5'd0;
    localparam t_upc UPC_MUL       = 5'd1;
    localparam t_upc UPC_TEST      = 5'd2;
    localparam t_upc UPC_NEXT_DIV  = 5'd3;
    localparam t_upc UPC_NEXT_BAND = 5'd4;
    localparam t_upc UPC_FAIL      = 5'd5;
    localparam t_upc UPC_TX_INIT   = 5'd6;
    localparam t_upc UPC_TX_EST    = 5'd7;
    localparam t_upc UPC_TX_BMUL   = 5'd8;
    localparam t_upc UPC_TX_SUB    = 5'd9;
    localparam t_upc UPC_TX_FIX    = 5'd10;
    localparam t_upc UPC_TX_STORE  = 5'd11;
    localparam t_upc UPC_RX_MUL    = 5'd12;
    localparam t_upc UPC_RX_INIT   = 5'd13;
    localparam t_upc UPC_RX_EST    = 5'd14;
    localparam t_upc UPC_RX_BMUL   = 5'd15;
    localparam t_upc UPC_RX_SUB    = 5'd16;
    localparam t_upc UPC_RX_FIX    = 5'd17;
    localparam t_upc UPC_FINISH    = 5'd18;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic in_band;
        logic last_div;
        logic first_band;
        logic cnt_nz;
    } t_flags;

endpackage

### src/pfwc_urom.sv
module pfwc_urom (
    input  pfwc_pkg::t_upc   i_upc,
    output pfwc_pkg::t_uword o_uword
);

    // branch taken when cond holds, otherwise fall through to the next step
    always_comb begin
        case (i_upc)
            pfwc_pkg::UPC_IDLE:
                o_uword = '{pfwc_pkg::OP_LOAD, pfwc_pkg::C_NO_START, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_MUL:
                o_uword = '{pfwc_pkg::OP_MUL_TX, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_TEST:
                o_uword = '{pfwc_pkg::OP_NONE, pfwc_pkg::C_IN_BAND, pfwc_pkg::UPC_TX_INIT};
            pfwc_pkg::UPC_NEXT_DIV:
                o_uword = '{pfwc_pkg::OP_INC_DIV, pfwc_pkg::C_NOT_LAST_DIV,
                            pfwc_pkg::UPC_MUL};
            pfwc_pkg::UPC_NEXT_BAND:
                o_uword = '{pfwc_pkg::OP_NEXT_BAND, pfwc_pkg::C_FIRST_BAND,
                            pfwc_pkg::UPC_MUL};
            pfwc_pkg::UPC_FAIL:
                o_uword = '{pfwc_pkg::OP_FAIL, pfwc_pkg::C_ALWAYS, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_TX_INIT:
                o_uword = '{pfwc_pkg::OP_DIV_INIT, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_TX_EST:
                o_uword = '{pfwc_pkg::OP_Q_EST, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_TX_BMUL:
                o_uword = '{pfwc_pkg::OP_Q_MUL, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_TX_SUB:
                o_uword = '{pfwc_pkg::OP_Q_SUB, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_TX_FIX:
                o_uword = '{pfwc_pkg::OP_Q_FIX, pfwc_pkg::C_CNT_NZ,
                            pfwc_pkg::UPC_TX_EST};
            pfwc_pkg::UPC_TX_STORE:
                o_uword = '{pfwc_pkg::OP_STORE_TX, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_RX_MUL:
                o_uword = '{pfwc_pkg::OP_MUL_RX, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_RX_INIT:
                o_uword = '{pfwc_pkg::OP_DIV_INIT, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_RX_EST:
                o_uword = '{pfwc_pkg::OP_Q_EST, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_RX_BMUL:
                o_uword = '{pfwc_pkg::OP_Q_MUL, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_RX_SUB:
                o_uword = '{pfwc_pkg::OP_Q_SUB, pfwc_pkg::C_NEVER, pfwc_pkg::UPC_IDLE};
            pfwc_pkg::UPC_RX_FIX:
                o_uword = '{pfwc_pkg::OP_Q_FIX, pfwc_pkg::C_CNT_NZ,
                            pfwc_pkg::UPC_RX_EST};
            pfwc_pkg::UPC_FINISH:
                o_uword = '{pfwc_pkg::OP_FINISH, pfwc_pkg::C_ALWAYS, pfwc_pkg::UPC_IDLE};
            default:
                o_uword = '{pfwc_pkg::OP_NONE, pfwc_pkg::C_ALWAYS, pfwc_pkg::UPC_IDLE};
        endcase
    end

endmodule

### src/pfwc_seq.sv
module pfwc_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pfwc_pkg::t_flags  i_flags,
    output pfwc_pkg::t_uword  o_uword,
    output logic              o_busy
);

    pfwc_pkg::t_upc   r_upc;
    pfwc_pkg::t_upc   n_upc;
    pfwc_pkg::t_uword uword;
    logic             take;

    pfwc_urom u_urom (
        .i_upc   (r_upc),
        .o_uword (uword)
    );

    always_comb begin
        case (uword.cond)
            pfwc_pkg::C_NEVER:        take = 1'b0;
            pfwc_pkg::C_ALWAYS:       take = 1'b1;
            pfwc_pkg::C_NO_START:     take = !i_start;
            pfwc_pkg::C_IN_BAND:      take = i_flags.in_band;
            pfwc_pkg::C_NOT_LAST_DIV: take = !i_flags.last_div;
            pfwc_pkg::C_FIRST_BAND:   take = i_flags.first_band;
            pfwc_pkg::C_CNT_NZ:       take = i_flags.cnt_nz;
            default:                  take = 1'b0;
        endcase
        n_upc = take ? uword.target : r_upc + pfwc_pkg::t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= pfwc_pkg::UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = uword;
    assign o_busy  = (r_upc != pfwc_pkg::UPC_IDLE);

endmodule

### src/pfwc_dp.sv
module pfwc_dp #(
    parameter int unsigned CRYSTAL_HZ = pfwc_pkg::CRYSTAL_HZ_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pfwc_pkg::t_uword             i_uword,
    input  logic [pfwc_pkg::FREQ_W-1:0]  i_frequency_hz,
    output pfwc_pkg::t_flags             o_flags,
    output logic                         o_done,
    output logic                         o_ok,
    output logic [7:0]                   o_bank [pfwc_pkg::BANK_BYTES]
);

    localparam int          REM_W     = $clog2(CRYSTAL_HZ);
    localparam int          SUM_W     = pfwc_pkg::FREQ_W + 1;
    localparam int          MULRX_W   = pfwc_pkg::MUL_W + 1;
    localparam int unsigned RX_OFFSET = CRYSTAL_HZ / pfwc_pkg::RX_OFFSET_DIV;
    localparam int          FW        = pfwc_pkg::FRAC_W;
    localparam int          DW        = pfwc_pkg::DIG_W;
    // numerator is the VCO frequency or a remainder shifted up by one digit
    localparam int          NUM_W     = (REM_W + DW > pfwc_pkg::FVCO_W) ?
                                        REM_W + DW : pfwc_pkg::FVCO_W;
    // reciprocal scaled so the estimate is low by at most one
    localparam longint unsigned RECIP = (64'd1 << NUM_W) / 64'(CRYSTAL_HZ);
    localparam int          RECIP_W   = $clog2(RECIP + 64'd1);
    localparam int          PROD_W    = NUM_W + RECIP_W;

    logic [pfwc_pkg::FREQ_W-1:0] r_freq;
    logic [pfwc_pkg::IDX_W-1:0]  r_idx;
    logic                        r_band;     // 1: low VCO band
    logic [pfwc_pkg::MUL_W-1:0]  r_fvco;
    logic [NUM_W-1:0]            r_num;
    logic [RECIP_W-1:0]          r_q;
    logic [NUM_W-1:0]            r_prod;
    logic [REM_W:0]              r_rem;
    logic [pfwc_pkg::INT_W-1:0]  r_n;
    logic [FW-1:0]               r_k;
    logic [pfwc_pkg::CNT_W-1:0]  r_cnt;
    logic [7:0]                  r_bank [pfwc_pkg::BANK_BYTES];
    logic                        r_ok;
    logic                        r_done;

    logic [pfwc_pkg::DIVV_W-1:0] div_val;
    logic [pfwc_pkg::MUL_W-1:0]  mul_tx;
    logic [SUM_W-1:0]            rx_sum;
    logic [MULRX_W-1:0]          mul_rx;
    logic [PROD_W-1:0]           est_prod;
    logic [NUM_W-1:0]            back_prod;
    logic [NUM_W-1:0]            rem_raw;
    logic                        fix;
    logic [REM_W:0]              rem_sub;
    logic [REM_W-1:0]            rem_fix;
    logic [RECIP_W-1:0]          q_fix;
    logic                        round_up;
    logic [FW:0]                 k_word;
    logic [pfwc_pkg::INT_W-1:0]  n_word;

    always_comb begin
        div_val = pfwc_pkg::div_value(r_idx);
        mul_tx  = pfwc_pkg::MUL_W'(r_freq) * pfwc_pkg::MUL_W'(div_val);
        rx_sum  = SUM_W'(r_freq) + SUM_W'(RX_OFFSET);
        mul_rx  = MULRX_W'(rx_sum) * MULRX_W'(div_val);

        // quotient digit: reciprocal estimate, back multiply, subtract, correct
        est_prod  = PROD_W'(r_num) * PROD_W'(RECIP);
        back_prod = NUM_W'(r_q) * NUM_W'(CRYSTAL_HZ);
        rem_raw   = r_num - r_prod;
        fix       = (r_rem >= (REM_W + 1)'(CRYSTAL_HZ));
        rem_sub   = r_rem - (REM_W + 1)'(CRYSTAL_HZ);
        rem_fix   = fix ? rem_sub[REM_W-1:0] : r_rem[REM_W-1:0];
        q_fix     = r_q + RECIP_W'(fix);

        // round half up: final remainder at least half the crystal
        round_up = ({r_rem, 1'b0} >= (REM_W + 2)'(CRYSTAL_HZ));
        k_word   = (FW + 1)'(r_k) + (FW + 1)'(round_up);
        n_word   = r_n;

        if (r_band) begin
            o_flags.in_band = (r_fvco >= pfwc_pkg::LO_BAND_MIN)
                           && (r_fvco <= pfwc_pkg::LO_BAND_MAX);
        end else begin
            o_flags.in_band = (r_fvco >= pfwc_pkg::HI_BAND_MIN)
                           && (r_fvco <= pfwc_pkg::HI_BAND_MAX);
        end
        o_flags.last_div   = (r_idx == pfwc_pkg::IDX_W'(pfwc_pkg::NUM_DIVS - 1));
        o_flags.first_band = !r_band;
        o_flags.cnt_nz     = (r_cnt != '0);
    end

    // sequencing datapath registers
    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            pfwc_pkg::OP_LOAD: begin
                r_freq <= i_frequency_hz;
                r_idx  <= '0;
                r_band <= 1'b0;
            end
            pfwc_pkg::OP_MUL_TX: begin
                r_fvco <= mul_tx;
            end
            pfwc_pkg::OP_INC_DIV: begin
                r_idx <= r_idx + pfwc_pkg::IDX_W'(1);
            end
            pfwc_pkg::OP_NEXT_BAND: begin
                r_idx  <= '0;
                r_band <= 1'b1;
            end
            pfwc_pkg::OP_DIV_INIT: begin
                r_num <= NUM_W'(r_fvco[pfwc_pkg::FVCO_W-1:0]);
                r_cnt <= pfwc_pkg::CNT_W'(pfwc_pkg::FRAC_DIGITS);
            end
            pfwc_pkg::OP_Q_EST: begin
                r_q <= est_prod[NUM_W +: RECIP_W];
            end
            pfwc_pkg::OP_Q_MUL: begin
                r_prod <= back_prod;
            end
            pfwc_pkg::OP_Q_SUB: begin
                r_rem <= rem_raw[REM_W:0];
            end
            pfwc_pkg::OP_Q_FIX: begin
                r_rem <= {1'b0, rem_fix};
                r_num <= NUM_W'({rem_fix, DW'(0)});
                // first digit is N, then the fraction digits high first
                if (r_cnt == pfwc_pkg::CNT_W'(pfwc_pkg::FRAC_DIGITS)) begin
                    r_n <= q_fix[pfwc_pkg::INT_W-1:0];
                end else begin
                    r_k <= {r_k[FW-DW-1:0], q_fix[DW-1:0]};
                end
                r_cnt <= r_cnt - pfwc_pkg::CNT_W'(1);
            end
            pfwc_pkg::OP_MUL_RX: begin
                r_fvco <= mul_rx[pfwc_pkg::MUL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // bank and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= pfwc_pkg::BANK_RESET;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (i_uword.op)
                pfwc_pkg::OP_FAIL: begin
                    r_done <= 1'b1;
                    r_ok   <= 1'b0;
                end
                pfwc_pkg::OP_STORE_TX: begin
                    r_bank[4] <= n_word;
                    r_bank[5] <= k_word[7:0];
                    r_bank[6] <= k_word[15:8];
                    r_bank[7] <= {r_bank[7][7],
                                  r_band ? pfwc_pkg::VCO_BANK_LO : pfwc_pkg::VCO_BANK_HI,
                                  k_word[19:16]};
                end
                pfwc_pkg::OP_FINISH: begin
                    r_bank[0] <= n_word;
                    r_bank[1] <= k_word[7:0];
                    r_bank[2] <= k_word[15:8];
                    r_bank[3] <= {r_bank[3][7], pfwc_pkg::div_code(r_idx), k_word[19:16]};
                    r_done    <= 1'b1;
                    r_ok      <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_ok   = r_ok;
    assign o_bank = r_bank;

endmodule

### src/pll_frequency_word_calc_top.sv
// PLL frequency word calculator. Pulse start while busy is low to hand in a
// carrier frequency; busy then stays high until the result word is out. The
// result appears for exactly one cycle with o_done high and cannot be held
// off, so the receiver must take it in that cycle. o_ok low means no output
// divider put the VCO in either band; the bank bytes then show the old,
// unchanged bank. A small microcode program runs a divider search (multiply,
// band test and step to the next divider for each divider tried) and two
// divisions by the crystal frequency, each as an integer digit and two
// 10-bit fraction digits; a digit takes four steps (reciprocal estimate,
// back multiply, subtract, correct). busy falls in the result cycle, so the
// next word can be taken at the same edge as the result.
module pll_frequency_word_calc_top #(
    parameter int unsigned CRYSTAL_HZ = pfwc_pkg::CRYSTAL_HZ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_frequency_hz,
    output logic        o_done,
    output logic        o_ok,
    output logic [7:0]  o_rx_int,
    output logic [7:0]  o_rx_frac_low,
    output logic [7:0]  o_rx_frac_mid,
    output logic [7:0]  o_rx_ctrl,
    output logic [7:0]  o_tx_int,
    output logic [7:0]  o_tx_frac_low,
    output logic [7:0]  o_tx_frac_mid,
    output logic [7:0]  o_tx_ctrl
);

    pfwc_pkg::t_uword uword;
    pfwc_pkg::t_flags flags;
    logic [7:0]       bank [pfwc_pkg::BANK_BYTES];

    pfwc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_uword (uword),
        .o_busy  (busy)
    );

    pfwc_dp #(
        .CRYSTAL_HZ (CRYSTAL_HZ)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uword        (uword),
        .i_frequency_hz (i_frequency_hz),
        .o_flags        (flags),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_bank         (bank)
    );

    assign o_rx_int      = bank[0];
    assign o_rx_frac_low = bank[1];
    assign o_rx_frac_mid = bank[2];
    assign o_rx_ctrl     = bank[3];
    assign o_tx_int      = bank[4];
    assign o_tx_frac_low = bank[5];
    assign o_tx_frac_mid = bank[6];
    assign o_tx_ctrl     = bank[7];

endmodule
